// ===== rtl/ssa_pkg.sv =====
// Shared types and constants for the sized slot allocator.
// No dependencies; imported by the top level and its port checker.
package ssa_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int SIZE_LIMIT_DEF = 255;

    localparam int ACT_W    = 2;
    localparam int HANDLE_W = 11;
    localparam int SIZE_W   = 8;
    localparam int MARK_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET   = 2'd0,
        ACT_DEL   = 2'd1,
        ACT_SWEEP = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    localparam logic [MARK_W-1:0] MARK_FREE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_PENDING = 2'd2;

endpackage

// ===== rtl/sized_slot_allocator.sv =====
// Top level of the sized slot allocator: slot table memory and its sequencer.
// Depends on ssa_pkg.

// One request is worked on at a time. A lookup or delete by handle reads the
// slot table and then checks the slot; the write back of a delete shares the
// cycle that checks the slot. Allocation, sweep and clear walk the table through
// its single read port and single write port, one slot a cycle, up to the
// high-water mark (at most SLOT_COUNT). A failed allocation check or a sweep
// with nothing pending goes straight to the result. The result sits in an output
// register, so the next request may be sent before the last result is taken.
// Slots beyond the highest slot ever written read as free and unsized through a
// fill count, so no clearing pass is needed after reset.
module sized_slot_allocator
    import ssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SIZE_LIMIT = SIZE_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [HANDLE_W-1:0] i_slot_handle,
    input  logic [SIZE_W-1:0]   i_bone_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_ok,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [SIZE_W-1:0]   o_size_out
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MW    = $clog2(SLOT_COUNT + 1);
    localparam int CW    = (MW > HANDLE_W) ? MW : HANDLE_W;
    localparam int EW    = MARK_W + SIZE_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHK   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SWEEP = 7'b0001000,
        S_CLEAR = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    t_action             r_act, n_act;
    logic [SIZE_W-1:0]   r_want, n_want;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [MW-1:0]       r_mark, n_mark;
    logic [MW-1:0]       r_fill;
    logic                r_pend, n_pend;
    logic [MW-1:0]       r_last, n_last;
    logic [MW-1:0]       r_ptr, n_ptr;
    logic                r_dv, n_dv;
    logic [MW-1:0]       r_chk, n_chk;
    logic                r_cand_v, n_cand_v;
    logic [IDX_W-1:0]    r_cand, n_cand;
    logic [MW-1:0]       r_top, n_top;
    logic                r_res_ok, n_res_ok;
    logic [HANDLE_W-1:0] r_res_h, n_res_h;
    logic [SIZE_W-1:0]   r_res_s, n_res_s;
    logic                r_o_valid, n_o_valid;
    logic                r_o_ok, n_o_ok;
    logic [HANDLE_W-1:0] r_o_h, n_o_h;
    logic [SIZE_W-1:0]   r_o_s, n_o_s;

    // Slot table: use mark in the upper bits, size in the lower bits.
    logic [EW-1:0]       r_mem [SLOT_COUNT];
    logic [EW-1:0]       r_rdata;
    logic                r_rd_zero;

    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_wa, mem_ra;
    logic [EW-1:0]       mem_wd;

    logic [MARK_W-1:0]   rd_mark;
    logic [SIZE_W-1:0]   rd_size;
    logic                lk_ok, bad_size, free0, reuse;
    logic [IDX_W-1:0]    lk_idx, scan_sel;

    assign rd_mark = r_rd_zero ? MARK_FREE : r_rdata[EW-1:SIZE_W];
    assign rd_size = r_rd_zero ? '0 : r_rdata[SIZE_W-1:0];

    assign lk_ok    = (i_slot_handle != '0) && (CW'(i_slot_handle) <= CW'(r_mark));
    assign lk_idx   = IDX_W'(i_slot_handle - HANDLE_W'(1));
    assign bad_size = (i_bone_count == '0) || (32'(i_bone_count) > SIZE_LIMIT);

    assign free0    = (rd_mark == MARK_FREE) && (rd_size == '0);
    assign reuse    = (r_chk < r_mark) && (rd_mark == MARK_FREE) && (rd_size == r_want);
    assign scan_sel = r_cand_v ? r_cand : IDX_W'(r_chk);

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_ok         = r_o_ok;
    assign o_handle_out = r_o_h;
    assign o_size_out   = r_o_s;

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_want    = r_want;
        n_idx     = r_idx;
        n_mark    = r_mark;
        n_pend    = r_pend;
        n_last    = r_last;
        n_ptr     = r_ptr;
        n_dv      = r_dv;
        n_chk     = r_chk;
        n_cand_v  = r_cand_v;
        n_cand    = r_cand;
        n_top     = r_top;
        n_res_ok  = r_res_ok;
        n_res_h   = r_res_h;
        n_res_s   = r_res_s;
        n_o_valid = r_o_valid & ~i_ready;
        n_o_ok    = r_o_ok;
        n_o_h     = r_o_h;
        n_o_s     = r_o_s;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act    = t_action'(i_action);
                    n_want   = i_bone_count;
                    n_idx    = lk_idx;
                    n_res_ok = 1'b0;
                    n_res_h  = '0;
                    n_res_s  = '0;
                    n_dv     = 1'b0;
                    n_ptr    = '0;
                    n_state  = S_OUT;
                    unique case (t_action'(i_action))
                        ACT_GET, ACT_DEL: begin
                            if ((t_action'(i_action) == ACT_GET) && (i_slot_handle == '0)) begin
                                if (!bad_size) begin
                                    n_last   = (r_mark < MW'(SLOT_COUNT)) ? r_mark
                                                                          : MW'(SLOT_COUNT - 1);
                                    n_cand_v = 1'b0;
                                    n_state  = S_SCAN;
                                end
                            end else if (lk_ok) begin
                                mem_re  = 1'b1;
                                mem_ra  = lk_idx;
                                n_state = S_CHK;
                            end
                        end
                        ACT_SWEEP: begin
                            if (r_pend) begin
                                n_pend   = 1'b0;
                                n_top    = '0;
                                n_res_ok = 1'b1;
                                n_state  = S_SWEEP;
                            end
                        end
                        ACT_CLEAR: begin
                            n_res_ok = (r_mark != '0);
                            n_ptr    = r_mark;
                            n_state  = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            S_CHK: begin
                if ((rd_mark == MARK_LIVE) &&
                    ((r_act == ACT_DEL) || (r_want == '0) || (rd_size == r_want))) begin
                    n_res_ok = 1'b1;
                    n_res_h  = HANDLE_W'(r_idx + 1);
                    n_res_s  = rd_size;
                    if (r_act == ACT_DEL) begin
                        mem_we = 1'b1;
                        mem_wa = r_idx;
                        mem_wd = {MARK_PENDING, rd_size};
                        n_pend = 1'b1;
                    end
                end
                n_state = S_OUT;
            end

            // One pass looks for a reusable slot below the mark and remembers the
            // lowest never-sized free slot in case no reuse is found.
            S_SCAN: begin
                n_dv = 1'b0;
                if (r_ptr <= r_last) begin
                    mem_re = 1'b1;
                    mem_ra = IDX_W'(r_ptr);
                    n_ptr  = MW'(r_ptr + 1'b1);
                    n_dv   = 1'b1;
                    n_chk  = r_ptr;
                end
                if (r_dv) begin
                    if (reuse) begin
                        mem_we   = 1'b1;
                        mem_wa   = IDX_W'(r_chk);
                        mem_wd   = {MARK_LIVE, r_want};
                        n_res_ok = 1'b1;
                        n_res_h  = HANDLE_W'(r_chk + 1'b1);
                        n_res_s  = r_want;
                        n_state  = S_OUT;
                    end else begin
                        if (!r_cand_v && free0) begin
                            n_cand_v = 1'b1;
                            n_cand   = IDX_W'(r_chk);
                        end
                        if (r_chk == r_last) begin
                            if (r_cand_v || free0) begin
                                mem_we   = 1'b1;
                                mem_wa   = scan_sel;
                                mem_wd   = {MARK_LIVE, r_want};
                                n_mark   = MW'(scan_sel) + MW'(1);
                                n_res_ok = 1'b1;
                                n_res_h  = HANDLE_W'(scan_sel + 1);
                                n_res_s  = r_want;
                            end
                            n_state = S_OUT;
                        end
                    end
                end
            end

            // Read each slot below the mark and free and write back the pending ones; the top
            // register tracks one past the highest slot left in use.
            S_SWEEP: begin
                n_dv = 1'b0;
                if (r_ptr < r_mark) begin
                    mem_re = 1'b1;
                    mem_ra = IDX_W'(r_ptr);
                    n_ptr  = MW'(r_ptr + 1'b1);
                    n_dv   = 1'b1;
                    n_chk  = r_ptr;
                end
                if (r_dv) begin
                    if (rd_mark == MARK_PENDING) begin
                        mem_we = 1'b1;
                        mem_wa = IDX_W'(r_chk);
                        mem_wd = {MARK_FREE, rd_size};
                    end else if (rd_mark != MARK_FREE) begin
                        n_top = MW'(r_chk + 1'b1);
                    end
                end else if (r_ptr == r_mark) begin
                    n_mark  = r_top;
                    n_state = S_OUT;
                end
            end

            S_CLEAR: begin
                if (r_ptr != '0) begin
                    mem_we = 1'b1;
                    mem_wa = IDX_W'(r_ptr - 1'b1);
                    mem_wd = {MARK_FREE, {SIZE_W{1'b0}}};
                    n_ptr  = MW'(r_ptr - 1'b1);
                end else begin
                    n_mark  = '0;
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_res_ok;
                    n_o_h     = r_res_h;
                    n_o_s     = r_res_s;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mark    <= '0;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mark    <= n_mark;
            r_pend    <= n_pend;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
            // Entries at or above the fill count have never been written.
            if (mem_we && (MW'(mem_wa) >= r_fill)) begin
                r_fill <= MW'(mem_wa) + MW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_want   <= n_want;
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_ptr    <= n_ptr;
        r_chk    <= n_chk;
        r_cand_v <= n_cand_v;
        r_cand   <= n_cand;
        r_top    <= n_top;
        r_res_ok <= n_res_ok;
        r_res_h  <= n_res_h;
        r_res_s  <= n_res_s;
        r_o_ok   <= n_o_ok;
        r_o_h    <= n_o_h;
        r_o_s    <= n_o_s;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata   <= r_mem[mem_ra];
            r_rd_zero <= !(MW'(mem_ra) < r_fill);
        end
    end

endmodule

// ===== rtl/ssa_check.sv =====
// Port checker for the sized slot allocator, bound to the top level below.
// Depends on ssa_pkg and on the sized_slot_allocator port list.
module ssa_check
    import ssa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [ACT_W-1:0]    i_action,
    input logic [HANDLE_W-1:0] i_slot_handle,
    input logic [SIZE_W-1:0]   i_bone_count,
    input logic                o_valid,
    input logic                i_ready,
    input logic                o_ok,
    input logic [HANDLE_W-1:0] o_handle_out,
    input logic [SIZE_W-1:0]   o_size_out
);

    // A result that is waiting must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ok) && $stable(o_handle_out)
                                && $stable(o_size_out))
        else $error("result changed while stalled");

    // A failed request reports neither a handle nor a size.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> (o_handle_out == '0) && (o_size_out == '0))
        else $error("failed result carries a handle or size");

    // Sweep and clear give no handle, and then no size either.
    a_no_handle_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_handle_out == '0) |-> (o_size_out == '0))
        else $error("size given without a handle");

    // Every slot handed out holds a nonzero size.
    a_slot_sized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok && (o_handle_out != '0) |-> (o_size_out != '0))
        else $error("slot reported with zero size");

    // The block takes one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

endmodule

bind sized_slot_allocator ssa_check u_ssa_check (.*);

// ===== tb/sized_slot_allocator_tb.sv =====
// Self-checking testbench for sized_slot_allocator: a directed table, a fill of the lower
// slots and random request sequences, each reply checked against a slot-table model or a known reply.
// Depends on ssa_pkg and the sized_slot_allocator RTL.
module sized_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssa_pkg::*;

    localparam int SLOTS           = SLOT_COUNT_DEF;
    localparam int FILL_SLOTS      = 256;
    localparam int RANDOM_REQUESTS = 290;
    localparam int IDLE_LIMIT      = 6000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int CROWDED_MARK    = 24;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } t_reply;

    typedef struct packed {
        t_action             act;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   count;
        logic                known;
        t_reply              reply;
    } t_probe;

    localparam t_reply NO_REPLY = '0;

    // Rows with known set carry the reply outright; the rest are left to the slot model.
    // No sweep here runs with the top slot pending, so no stale size is left above the mark.
    localparam t_probe OPENING [25] = '{
        '{ACT_SWEEP, 11'd0,    8'd0,   1'b1, NO_REPLY},
        '{ACT_CLEAR, 11'd0,    8'd0,   1'b1, NO_REPLY},
        '{ACT_GET,   11'd1,    8'd0,   1'b1, NO_REPLY},
        '{ACT_DEL,   11'd0,    8'd255, 1'b1, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd0,   1'b1, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd255, 1'b1, '{1'b1, 11'd1, 8'd255}},
        '{ACT_GET,   11'd0,    8'd1,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd128, 1'b0, NO_REPLY},
        '{ACT_GET,   11'd1,    8'd0,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd2,    8'd7,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd3,    8'd128, 1'b0, NO_REPLY},
        '{ACT_GET,   11'd4,    8'd0,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd2047, 8'd255, 1'b1, NO_REPLY},
        '{ACT_GET,   11'd1024, 8'd0,   1'b1, NO_REPLY},
        '{ACT_DEL,   11'd1,    8'd85,  1'b0, NO_REPLY},
        '{ACT_GET,   11'd1,    8'd255, 1'b0, NO_REPLY},
        '{ACT_DEL,   11'd1,    8'd0,   1'b0, NO_REPLY},
        '{ACT_DEL,   11'd2,    8'd170, 1'b0, NO_REPLY},
        '{ACT_SWEEP, 11'd0,    8'd0,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd1,   1'b0, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd255, 1'b0, NO_REPLY},
        '{ACT_GET,   11'd0,    8'd255, 1'b0, NO_REPLY},
        '{ACT_DEL,   11'd3,    8'd0,   1'b0, NO_REPLY},
        '{ACT_CLEAR, 11'd0,    8'd0,   1'b0, NO_REPLY},
        '{ACT_SWEEP, 11'd0,    8'd0,   1'b0, NO_REPLY}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    t_action             i_action      = ACT_GET;
    logic [HANDLE_W-1:0] i_slot_handle = '0;
    logic [SIZE_W-1:0]   i_bone_count  = '0;
    logic                i_ready       = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic                o_ok;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [SIZE_W-1:0]   o_size_out;

    // Slot-table model state.
    logic [MARK_W-1:0] use_tbl [SLOTS];
    logic [SIZE_W-1:0] size_tbl [SLOTS];
    int                top_mark;
    bit                sweep_owed;

    t_reply replies_due [$];
    int     reply_faults = 0;
    int     quiet_cycles = 0;
    bit     hold_go      = 1'b0;
    logic   rx_hold      = 1'b0;

    sized_slot_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_slot_handle (i_slot_handle),
        .i_bone_count  (i_bone_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ok          (o_ok),
        .o_handle_out  (o_handle_out),
        .o_size_out    (o_size_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int live_slot(logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] count);
        int idx;
        if (handle == 0) return -1;
        idx = int'(handle) - 1;
        if (idx >= top_mark || idx >= SLOTS) return -1;
        if (use_tbl[idx] != MARK_LIVE) return -1;
        if (count != 0 && size_tbl[idx] != count) return -1;
        return idx;
    endfunction

    // Reuse a freed slot of the same size below the mark, else take the lowest unsized
    // free slot at or below it. A sized slot at the mark blocks the second search.
    function automatic int grant_slot(logic [SIZE_W-1:0] count);
        int last;
        if (count == 0 || int'(count) > SIZE_LIMIT_DEF) return -1;
        for (int i = 0; i < top_mark && i < SLOTS; i++) begin
            if (use_tbl[i] == MARK_FREE && size_tbl[i] == count) begin
                use_tbl[i] = MARK_LIVE;
                return i;
            end
        end
        last = (top_mark < SLOTS) ? top_mark : SLOTS - 1;
        for (int i = 0; i <= last; i++) begin
            if (use_tbl[i] == MARK_FREE && size_tbl[i] == 0) begin
                size_tbl[i] = count;
                use_tbl[i]  = MARK_LIVE;
                top_mark    = i + 1;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_reply apply_slot_op(t_action act, logic [HANDLE_W-1:0] handle,
                                             logic [SIZE_W-1:0] count);
        int     idx;
        t_reply r;
        r = NO_REPLY;
        case (act)
            ACT_GET: begin
                idx = (handle == 0) ? grant_slot(count) : live_slot(handle, count);
                if (idx >= 0) r = '{1'b1, HANDLE_W'(idx + 1), size_tbl[idx]};
            end
            ACT_DEL: begin
                idx = live_slot(handle, '0);
                if (idx >= 0) begin
                    use_tbl[idx] = MARK_PENDING;
                    sweep_owed   = 1'b1;
                    r            = '{1'b1, HANDLE_W'(idx + 1), size_tbl[idx]};
                end
            end
            ACT_SWEEP: begin
                if (sweep_owed) begin
                    sweep_owed = 1'b0;
                    for (int i = 0; i < top_mark; i++) begin
                        if (use_tbl[i] == MARK_PENDING) use_tbl[i] = MARK_FREE;
                    end
                    while (top_mark > 0 && use_tbl[top_mark - 1] == MARK_FREE) top_mark--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                r.ok = (top_mark != 0);
                while (top_mark > 0) begin
                    top_mark--;
                    size_tbl[top_mark] = '0;
                    use_tbl[top_mark]  = MARK_FREE;
                end
            end
        endcase
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request and holds it until the transfer. With a gap of zero, valid stays
    // high so that the next call can present its request straight away.
    task automatic issue(input t_action act, input logic [HANDLE_W-1:0] handle,
                         input logic [SIZE_W-1:0] count, input int gap,
                         input logic known = 1'b0, input t_reply known_reply = NO_REPLY);
        t_reply due;
        i_valid       <= 1'b1;
        i_action      <= act;
        i_slot_handle <= handle;
        i_bone_count  <= count;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        due = apply_slot_op(act, handle, count);
        replies_due.push_back(known ? known_reply : due);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic await_replies();
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Deleting the top slot is held back until late in the run: once it is swept the
    // mark drops below a sized slot, and that slot can never be allocated again.
    task automatic pick_request(output t_action act, output logic [HANDLE_W-1:0] handle,
                                output logic [SIZE_W-1:0] count, input bit top_ok);
        int roll;
        int reach;
        roll   = $urandom_range(0, 99);
        act    = ACT_GET;
        handle = HANDLE_W'($urandom_range(0, 1024));
        count  = SIZE_W'($urandom_range(0, 255));
        reach  = top_ok ? top_mark : top_mark - 1;
        if (roll < 40) begin
            handle = '0;
            roll   = $urandom_range(0, 19);
            if (roll < 13) begin
                count = SIZE_W'($urandom_range(1, 4));
            end else if (roll == 19) begin
                count = '0;
            end
        end else if (roll < 62) begin
            handle = HANDLE_W'($urandom_range(1, top_mark + 1));
            if ($urandom_range(0, 1) == 0) begin
                count = '0;
            end else if (handle <= top_mark && $urandom_range(0, 3) != 0) begin
                count = size_tbl[handle - 1];
            end
        end else if (roll < 80) begin
            act    = ACT_DEL;
            handle = (reach >= 1) ? HANDLE_W'($urandom_range(1, reach)) : '0;
        end else if (roll < 90) begin
            act = ACT_SWEEP;
        end else begin
            act = t_action'($urandom_range(0, 3));
            if (act == ACT_DEL && handle == top_mark && !top_ok) handle = '0;
        end
    endtask

    initial begin
        t_action             act;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   count;
        int                  issued;
        int                  run_len;
        bit                  drain;
        foreach (use_tbl[i]) begin
            use_tbl[i]  = MARK_FREE;
            size_tbl[i] = '0;
        end
        top_mark   = 0;
        sweep_owed = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[k]) begin
            issue(OPENING[k].act, OPENING[k].handle, OPENING[k].count,
                  (k == $size(OPENING) - 1) ? 1 : idle_span(),
                  OPENING[k].known, OPENING[k].reply);
        end
        await_replies();

        // Fill the lower slots back to back, then work the table around its top.
        for (int n = 0; n < FILL_SLOTS; n++) begin
            issue(ACT_GET, '0, SIZE_W'($urandom_range(1, 255)), 0);
        end
        issue(ACT_GET, '0, 8'd200, idle_span());
        issue(ACT_GET, HANDLE_W'(FILL_SLOTS + 1), 8'd0, idle_span());
        issue(ACT_GET, HANDLE_W'(FILL_SLOTS + 2), 8'd0, idle_span());
        issue(ACT_DEL, HANDLE_W'(FILL_SLOTS + 1), 8'd0, idle_span());
        issue(ACT_DEL, HANDLE_W'(FILL_SLOTS / 2), 8'd0, idle_span());
        issue(ACT_DEL, 11'd1, 8'd0, idle_span());
        issue(ACT_SWEEP, '0, '0, idle_span());
        issue(ACT_GET, '0, size_tbl[0], idle_span());
        issue(ACT_GET, '0, size_tbl[FILL_SLOTS / 2 - 1], idle_span());
        // The freed top slot keeps its size and now sits at the mark.
        issue(ACT_GET, '0, 8'd200, idle_span());
        issue(ACT_CLEAR, '0, '0, 1);
        await_replies();

        hold_go = 1'b1;
        issued  = 0;
        while (issued < RANDOM_REQUESTS) begin
            run_len = $urandom_range(6, 40);
            while (run_len > 0 && issued < RANDOM_REQUESTS && top_mark < CROWDED_MARK) begin
                pick_request(act, handle, count, issued >= RANDOM_REQUESTS * 85 / 100);
                issue(act, handle, count, idle_span());
                issued++;
                run_len--;
            end
            drain = ($urandom_range(0, 3) == 0) || (issued + 1 >= RANDOM_REQUESTS);
            issue(ACT_CLEAR, HANDLE_W'($urandom_range(0, 1024)),
                  SIZE_W'($urandom_range(0, 255)), drain ? 1 : idle_span());
            issued++;
            if (drain) await_replies();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reply_faults == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result side: short and long stalls, with calm stretches in between.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (calm_left > 0) begin
                calm_left--;
            end else begin
                calm_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(0, 12);
                stall_left = idle_span();
            end
            i_ready <= (stall_left == 0) && !rx_hold;
        end
    end

    // A single long hold-off on the result side while requests keep coming.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_reply due;
        if (i_rst_n && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                reply_faults++;
                if (reply_faults <= 10) begin
                    $display("reply with nothing outstanding: ok=%0d handle=%0d size=%0d",
                             o_ok, o_handle_out, o_size_out);
                end
            end else begin
                due = replies_due.pop_front();
                if (o_ok !== due.ok || o_handle_out !== due.handle
                        || o_size_out !== due.size) begin
                    reply_faults++;
                    if (reply_faults <= 10) begin
                        $display("reply mismatch: wanted ok=%0d handle=%0d size=%0d, %s%0d %0d %0d",
                                 due.ok, due.handle, due.size, "got ",
                                 o_ok, o_handle_out, o_size_out);
                    end
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
